// ===== hdl/lbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpr_pkg
// Shared types and constants for the lru block pool replacer.
// ----------------------------------------------------------------------------
package lbpr_pkg;

    localparam int POOL_SIZE  = 8;
    localparam int ADDR_WIDTH = 24;

    localparam int POS_W  = 24;
    localparam int BLK_W  = 24;
    localparam int OFF_W  = 12;
    localparam int BS_W   = 13;
    localparam int HPOS_W = 3;
    localparam int IDX_W  = $clog2(POOL_SIZE);

    localparam logic [BS_W-1:0] BS_MIN = BS_W'(1);
    localparam logic [BS_W-1:0] BS_MAX = BS_W'(4096);

    // address bits kept from the requested position
    localparam logic [POS_W-1:0] POS_MASK =
        (ADDR_WIDTH >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    // one quotient bit per divider step
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [BLK_W-1:0] quotient;
        logic [OFF_W-1:0] remainder;
    } div_result_t;

endpackage

// ===== hdl/lru_block_pool_replacer_unit.sv =====
// ----------------------------------------------------------------------------
// lru_block_pool_replacer_unit
// Splits a byte position by the block size and keeps an lru list of blocks.
// sequence: once start is taken the divider runs, then a walk of one to eight entries
//   through the single read port of the list leads to done
// handshake: no new transaction is taken while busy, and busy stays high until done
// reset: block size 4096, list holds blocks 0..7 in order via per-entry valid bits
// the receiver cannot stall: each result is shown with done for one cycle
// ----------------------------------------------------------------------------
module lru_block_pool_replacer_unit
    import lbpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              block_size_we,
    input  logic [BS_W-1:0]   block_size_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [POS_W-1:0]  byte_position,
    output logic              done,
    output logic [BLK_W-1:0]  block_number,
    output logic [OFF_W-1:0]  block_offset,
    output logic              hit,
    output logic [HPOS_W-1:0] hit_position,
    output logic [BLK_W-1:0]  evicted_block
);

    state_t              state_reg, state_next;
    logic [BS_W-1:0]     block_size_reg;
    logic [BS_W-1:0]     eff_bs;
    logic                accept;

    logic                div_done;
    div_result_t         div_res;

    logic [BLK_W-1:0]    order_mem [POOL_SIZE];
    logic [BLK_W-1:0]    rd_data_reg;
    logic [POOL_SIZE-1:0] valid_reg;
    logic                mem_re;
    logic                mem_we;
    logic [IDX_W-1:0]    rd_addr;

    logic [IDX_W-1:0]    idx_reg;
    logic [BLK_W-1:0]    carry_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                hit_reg;
    logic [HPOS_W-1:0]   hit_pos_reg;
    logic [BLK_W-1:0]    evicted_reg;

    logic [BLK_W-1:0]    entry;
    logic                match;
    logic                last;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);

    always_comb
    begin
        if (block_size_reg == '0)
            eff_bs = BS_MIN;
        else if (block_size_reg > BS_MAX)
            eff_bs = BS_MAX;
        else
            eff_bs = block_size_reg;
    end

    lbpr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (byte_position & POS_MASK),
        .divisor  (eff_bs),
        .done     (div_done),
        .result   (div_res)
    );

    // entry not yet written still holds its reset block number
    assign entry = valid_reg[idx_reg] ? rd_data_reg : BLK_W'(idx_reg);
    assign match = (entry == blk_reg);
    assign last  = (idx_reg == IDX_W'(POOL_SIZE - 1));

    // walk: each visited entry takes the one ahead of it, stop on a match or at the last entry
    assign mem_we  = (state_reg == S_SCAN);
    assign mem_re  = ((state_reg == S_DIV) && div_done)
                     || ((state_reg == S_SCAN) && !match && !last);
    assign rd_addr = (state_reg == S_SCAN) ? idx_reg + IDX_W'(1) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            order_mem[idx_reg] <= carry_reg;
        if (mem_re)
            rd_data_reg <= order_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_SCAN;
            S_SCAN:
                if (match || last)
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            block_size_reg <= BS_MAX;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (block_size_we)
                block_size_reg <= block_size_wdata;
            if (mem_we)
                valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV) && div_done)
        begin
            blk_reg   <= div_res.quotient;
            off_reg   <= div_res.remainder;
            carry_reg <= div_res.quotient;
            idx_reg   <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (match)
            begin
                hit_reg     <= 1'b1;
                hit_pos_reg <= HPOS_W'(idx_reg);
                evicted_reg <= '0;
            end
            else if (last)
            begin
                hit_reg     <= 1'b0;
                hit_pos_reg <= '0;
                evicted_reg <= entry;
            end
            else
            begin
                carry_reg <= entry;
                idx_reg   <= idx_reg + IDX_W'(1);
            end
        end
    end

    assign block_number  = blk_reg;
    assign block_offset  = off_reg;
    assign hit           = hit_reg;
    assign hit_position  = hit_pos_reg;
    assign evicted_block = evicted_reg;

endmodule

// ===== hdl/lbpr_divider.sv =====
// ----------------------------------------------------------------------------
// lbpr_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbpr_divider
    import lbpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [POS_W-1:0]    dividend,
    input  logic [BS_W-1:0]     divisor,
    output logic                done,
    output div_result_t         result
);

    logic                 active_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [BS_W-1:0]      divisor_reg;
    logic [OFF_W-1:0]     rem_reg;
    logic [BLK_W-1:0]     quo_reg;

    logic [BS_W-1:0]      trial;
    logic                 fits;
    logic [BS_W-1:0]      diff;

    // remainder stays below the divisor, so it fits in 12 bits
    assign trial = {rem_reg, quo_reg[BLK_W-1]};
    assign fits  = (trial >= divisor_reg);
    assign diff  = trial - divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                count_reg  <= '0;
            end
            else if (active_reg)
            begin
                count_reg <= count_reg + DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= dividend;
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
            quo_reg <= {quo_reg[BLK_W-2:0], fits};
        end
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== hdl/lbpr_checker.sv =====
// ----------------------------------------------------------------------------
// lbpr_props
// Port-level checks on the lru block pool replacer, bound to the top level.
// ----------------------------------------------------------------------------
module lbpr_props
    import lbpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  logic              hit,
    input  logic [HPOS_W-1:0] hit_position,
    input  logic [BLK_W-1:0]  evicted_block
);

    // a transaction, once taken, keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a transaction");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done longer than one cycle");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> evicted_block == '0)
        else $error("eviction reported on a hit");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_position == '0)
        else $error("hit position nonzero on a miss");

endmodule

bind lru_block_pool_replacer_unit lbpr_props u_lbpr_props (.*);

// ===== test/lbpr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbpr_checker
// Watches the request, result and block size ports of the lru block pool
// replacer, keeps its own copy of the recency list and block size, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lbpr_checker
    import lbpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              block_size_we,
    input  logic [BS_W-1:0]   block_size_wdata,
    input  logic              start,
    input  logic              busy,
    input  logic [POS_W-1:0]  byte_position,
    input  logic              done,
    input  logic [BLK_W-1:0]  block_number,
    input  logic [OFF_W-1:0]  block_offset,
    input  logic              hit,
    input  logic [HPOS_W-1:0] hit_position,
    input  logic [BLK_W-1:0]  evicted_block,
    output int                mismatch_count,
    output int                lookups_in_flight
);

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [OFF_W-1:0]  off;
        logic              hit;
        logic [HPOS_W-1:0] hpos;
        logic [BLK_W-1:0]  evicted;
    } lookup_result_t;

    logic [BS_W-1:0]  block_size_shadow;
    logic [BLK_W-1:0] resident_blocks [POOL_SIZE];
    lookup_result_t   expected_lookups [$];
    int               errors;

    assign mismatch_count = errors;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // split the position and update the recency list like the block does
    function automatic lookup_result_t predict_lookup(input logic [POS_W-1:0] pos);
        lookup_result_t   r;
        logic [POS_W-1:0] masked;
        logic [POS_W-1:0] eff;
        int               found;
        masked = pos & POS_MASK;
        if (block_size_shadow == '0)
            eff = POS_W'(BS_MIN);
        else if (block_size_shadow > BS_MAX)
            eff = POS_W'(BS_MAX);
        else
            eff = POS_W'(block_size_shadow);
        r.blk     = BLK_W'(masked / eff);
        r.off     = OFF_W'(masked % eff);
        r.evicted = '0;
        found     = -1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (found < 0 && resident_blocks[i] == r.blk)
                found = i;
        end
        if (found < 0)
        begin
            r.evicted = resident_blocks[POOL_SIZE-1];
            found     = POOL_SIZE - 1;
            r.hit     = 1'b0;
            r.hpos    = '0;
        end
        else
        begin
            r.hit  = 1'b1;
            r.hpos = HPOS_W'(found);
        end
        for (int i = found; i > 0; i--)
            resident_blocks[i] = resident_blocks[i-1];
        resident_blocks[0] = r.blk;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        lookup_result_t next_lookup;
        if (!rst_n)
        begin
            block_size_shadow = BS_MAX;
            for (int i = 0; i < POOL_SIZE; i++)
                resident_blocks[i] = BLK_W'(i);
            expected_lookups.delete();
            lookups_in_flight = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_lookups.size() == 0)
                    report_mismatch("unexpected result, block_number", block_number, 0);
                else
                begin
                    want = expected_lookups.pop_front();
                    if (block_number !== want.blk)
                        report_mismatch("block_number", block_number, want.blk);
                    if (block_offset !== want.off)
                        report_mismatch("block_offset", block_offset, want.off);
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (hit_position !== want.hpos)
                        report_mismatch("hit_position", hit_position, want.hpos);
                    if (evicted_block !== want.evicted)
                        report_mismatch("evicted_block", evicted_block, want.evicted);
                end
            end
            // a transaction taken on this edge still sees the old block size
            if (start && !busy)
            begin
                next_lookup      = predict_lookup(byte_position);
                expected_lookups = {expected_lookups, next_lookup};
            end
            if (block_size_we)
                block_size_shadow = block_size_wdata;
            lookups_in_flight = expected_lookups.size();
        end
    end

    initial
    begin
        errors            = 0;
        lookups_in_flight = 0;
    end

endmodule

// ===== test/tb_lru_block_pool_replacer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_block_pool_replacer_unit
// Drives byte positions and block size writes into the lru block pool
// replacer, with random gaps and back-to-back stretches; the checker beside
// the block predicts every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_lru_block_pool_replacer_unit
    import lbpr_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEMS_PER_SET  = 50;

    logic              clk;
    logic              rst_n;
    logic              block_size_we;
    logic [BS_W-1:0]   block_size_wdata;
    logic              start;
    logic              busy;
    logic [POS_W-1:0]  byte_position;
    logic              done;
    logic [BLK_W-1:0]  block_number;
    logic [OFF_W-1:0]  block_offset;
    logic              hit;
    logic [HPOS_W-1:0] hit_position;
    logic [BLK_W-1:0]  evicted_block;

    int                mismatch_count;
    int                lookups_in_flight;
    int                stall_cycles;
    int                eff_block_size;
    bit                back_to_back;

    lru_block_pool_replacer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .block_size_we    (block_size_we),
        .block_size_wdata (block_size_wdata),
        .start            (start),
        .busy             (busy),
        .byte_position    (byte_position),
        .done             (done),
        .block_number     (block_number),
        .block_offset     (block_offset),
        .hit              (hit),
        .hit_position     (hit_position),
        .evicted_block    (evicted_block)
    );

    lbpr_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .block_size_we     (block_size_we),
        .block_size_wdata  (block_size_wdata),
        .start             (start),
        .busy              (busy),
        .byte_position     (byte_position),
        .done              (done),
        .block_number      (block_number),
        .block_offset      (block_offset),
        .hit               (hit),
        .hit_position      (hit_position),
        .evicted_block     (evicted_block),
        .mismatch_count    (mismatch_count),
        .lookups_in_flight (lookups_in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic issue_lookup(input logic [POS_W-1:0] pos);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        byte_position <= pos;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        start <= 1'b0;
        do @(posedge clk); while (lookups_in_flight != 0 || busy);
    endtask

    task automatic write_block_size(input logic [BS_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        block_size_we    <= 1'b1;
        block_size_wdata <= value;
        @(negedge clk);
        block_size_we    <= 1'b0;
        if (value == '0)
            eff_block_size = 1;
        else if (value > BS_MAX)
            eff_block_size = int'(BS_MAX);
        else
            eff_block_size = int'(value);
    endtask

    // mostly blocks near the resident set so hits land at every depth
    task automatic random_lookups(input int count);
        logic [POS_W-1:0] pos;
        int               blk;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                back_to_back = ~back_to_back;
            if ($urandom_range(0, 4) != 0)
            begin
                blk = $urandom_range(0, 11);
                pos = POS_W'(blk * eff_block_size + $urandom_range(0, eff_block_size - 1));
            end
            else if ($urandom_range(0, 9) == 0)
                pos = '1;
            else
                pos = POS_W'($urandom());
            issue_lookup(pos);
        end
    endtask

    initial
    begin
        logic [BS_W-1:0] set_sizes [9];
        rst_n            = 1'b0;
        start            = 1'b0;
        block_size_we    = 1'b0;
        block_size_wdata = '0;
        byte_position    = '0;
        stall_cycles     = 0;
        eff_block_size   = int'(BS_MAX);
        back_to_back     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset block size: front hit, deepest hit, eviction, top of range
        issue_lookup(24'd0);
        issue_lookup(24'd4095);
        issue_lookup(24'd7 * 24'd4096);
        issue_lookup(24'd7 * 24'd4096 + 24'd1);
        issue_lookup(24'd8 * 24'd4096);
        issue_lookup(24'hFFFFFF);
        issue_lookup(24'd3 * 24'd4096 + 24'd17);
        issue_lookup(24'd6 * 24'd4096 + 24'd1000);

        // zero block size behaves as one byte per block
        write_block_size('0);
        issue_lookup(24'd5);
        issue_lookup(24'd5);
        issue_lookup(24'hFFFFFF);
        issue_lookup(24'd0);

        // oversized block size saturates
        write_block_size('1);
        issue_lookup(24'hFFFFFF);
        issue_lookup(24'h123456);
        issue_lookup(24'd0);

        set_sizes[0] = BS_W'(1);
        set_sizes[1] = BS_W'(4096);
        set_sizes[2] = BS_W'(4097);
        set_sizes[3] = BS_W'(2);
        set_sizes[4] = BS_W'(3);
        set_sizes[5] = BS_W'(7);
        set_sizes[6] = BS_W'(100);
        set_sizes[7] = BS_W'(1000);
        set_sizes[8] = BS_W'($urandom_range(1, 8191));
        foreach (set_sizes[i])
        begin
            write_block_size(set_sizes[i]);
            random_lookups(ITEMS_PER_SET);
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
